// ===== src/assert_macros.svh =====
// Assertion macros shared by the peer table RTL.
// No dependencies; included by the modules that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define PTWA_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define PTWA_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define PTWA_ASSERT(lbl, clk, rstn, prop, msg)
`define PTWA_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

// ===== src/ptwa_pkg.sv =====
// Types, constants and controller interface of the peer table with aging.
// No dependencies; used by every module of the block.
package ptwa_pkg;

    localparam int TABLE_DEPTH = 64;
    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam int CNT_W = IDX_W + 1;
    localparam logic [15:0] TIMEOUT_RESET = 16'd90;
    localparam int PADDR_W = 3;
    localparam logic REG_TIMEOUT = 1'b0;

    localparam logic [2:0] KIND_TICK      = 3'd0;
    localparam logic [2:0] KIND_SWEEP     = 3'd1;
    localparam logic [2:0] KIND_REGISTER  = 3'd2;
    localparam logic [2:0] KIND_KEEPALIVE = 3'd3;
    localparam logic [2:0] KIND_REQUEST   = 3'd4;

    typedef struct packed {
        logic [2:0]  kind;
        logic [63:0] node_id;
        logic [31:0] src_ip;
        logic [15:0] src_udp_port;
        logic [31:0] priv_ip;
        logic [15:0] priv_udp_port;
        logic [15:0] priv_tcp_port;
        logic [63:0] target_id;
    } in_item_t;

    typedef struct packed {
        logic [31:0] dest_ip;
        logic [15:0] dest_udp_port;
        logic [63:0] about_id;
        logic [31:0] pub_ip;
        logic [15:0] pub_udp_port;
        logic [15:0] pub_tcp_port;
        logic [31:0] local_ip;
        logic [15:0] local_udp_port;
        logic [15:0] local_tcp_port;
        logic        last;
    } out_item_t;

    typedef struct packed {
        logic capture;
        logic tick;
        logic sweep_start;
        logic sweep_step;
        logic write_reg;
        logic write_ka;
        logic read_entry;
        logic load_first;
        logic load_second;
    } cmd_t;

    typedef struct packed {
        logic [2:0] kind;
        logic       hit;
        logic       free_ok;
        logic       sweep_done;
    } status_t;

endpackage

// ===== src/ptwa_ctrl.sv =====
// Controller state machine of the peer table: sequences lookup, update,
// sweep and notify output. Depends on ptwa_pkg.
module ptwa_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    output logic              m_valid,
    input  logic              m_ready,
    input  ptwa_pkg::status_t st,
    output ptwa_pkg::cmd_t    cmd
);

    typedef enum logic [6:0] {
        ST_IDLE   = 7'b0000001,
        ST_LOOKUP = 7'b0000010,
        ST_DECIDE = 7'b0000100,
        ST_SWEEP  = 7'b0001000,
        ST_READ   = 7'b0010000,
        ST_OUT0   = 7'b0100000,
        ST_OUT1   = 7'b1000000
    } state_t;

    state_t state_reg, state_next;

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = (state_reg == ST_OUT0) || (state_reg == ST_OUT1);

    always_comb begin
        state_next = state_reg;
        cmd = '0;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.capture = 1'b1;
                    state_next = ST_LOOKUP;
                end
            end
            ST_LOOKUP: begin
                state_next = ST_DECIDE;
            end
            ST_DECIDE: begin
                state_next = ST_IDLE;
                case (st.kind)
                    ptwa_pkg::KIND_TICK: begin
                        cmd.tick = 1'b1;
                    end
                    ptwa_pkg::KIND_SWEEP: begin
                        cmd.sweep_start = 1'b1;
                        state_next = ST_SWEEP;
                    end
                    ptwa_pkg::KIND_REGISTER: begin
                        cmd.write_reg = st.hit || st.free_ok;
                    end
                    ptwa_pkg::KIND_KEEPALIVE: begin
                        cmd.write_ka = st.hit;
                    end
                    ptwa_pkg::KIND_REQUEST: begin
                        if (st.hit) begin
                            cmd.read_entry = 1'b1;
                            state_next = ST_READ;
                        end
                    end
                    default: begin
                        state_next = ST_IDLE;
                    end
                endcase
            end
            ST_SWEEP: begin
                if (st.sweep_done) begin
                    state_next = ST_IDLE;
                end else begin
                    cmd.sweep_step = 1'b1;
                end
            end
            ST_READ: begin
                cmd.load_first = 1'b1;
                state_next = ST_OUT0;
            end
            ST_OUT0: begin
                if (m_ready) begin
                    cmd.load_second = 1'b1;
                    state_next = ST_OUT1;
                end
            end
            ST_OUT1: begin
                if (m_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== src/ptwa_dp.sv =====
// Datapath of the peer table: id compare row, valid bits, entry memories,
// seconds clock, sweep walker and notify output register. Depends on ptwa_pkg.
`include "assert_macros.svh"
module ptwa_dp (
    input  logic                aclk,
    input  logic                aresetn,
    input  ptwa_pkg::cmd_t      cmd,
    output ptwa_pkg::status_t   st,
    input  ptwa_pkg::in_item_t  s_item,
    input  logic [15:0]         timeout,
    output ptwa_pkg::out_item_t m_item
);

    localparam int D = ptwa_pkg::TABLE_DEPTH;
    localparam int IW = ptwa_pkg::IDX_W;
    localparam int CW = ptwa_pkg::CNT_W;

    ptwa_pkg::in_item_t  item_reg;
    ptwa_pkg::out_item_t out_reg;

    logic [63:0]   id_reg [D];
    logic [D-1:0]  valid_reg;
    logic [31:0]   now_reg;

    logic [31:0] pub_ip_mem [D];
    logic [15:0] pub_udp_mem [D];
    logic [15:0] pub_tcp_mem [D];
    logic [31:0] priv_ip_mem [D];
    logic [31:0] priv_ports_mem [D];
    logic [31:0] seen_mem [D];

    logic [31:0] rd_pub_ip_reg;
    logic [15:0] rd_pub_udp_reg;
    logic [15:0] rd_pub_tcp_reg;
    logic [31:0] rd_priv_ip_reg;
    logic [31:0] rd_priv_ports_reg;
    logic [31:0] rd_seen_reg;

    logic [63:0]   key;
    logic [D-1:0]  match;
    logic          hit_next, free_next;
    logic [IW-1:0] hit_idx_next, free_idx_next;
    logic          hit_reg, free_ok_reg;
    logic [IW-1:0] hit_idx_reg, free_idx_reg;

    logic [CW-1:0] sweep_cnt_reg;
    logic          sweep_chk_reg;
    logic [IW-1:0] sweep_idx_reg;
    logic [31:0]   age;
    logic          expire;

    logic [IW-1:0] wr_idx;
    logic [31:0]   wr_ports;

    assign key = (item_reg.kind == ptwa_pkg::KIND_REQUEST) ? item_reg.target_id
                                                          : item_reg.node_id;

    always_comb begin
        hit_next = 1'b0;
        free_next = 1'b0;
        hit_idx_next = '0;
        free_idx_next = '0;
        for (int i = D - 1; i >= 0; i--) begin
            match[i] = valid_reg[i] && (id_reg[i] == key);
            if (match[i]) begin
                hit_next = 1'b1;
                hit_idx_next = IW'(i);
            end
            if (!valid_reg[i]) begin
                free_next = 1'b1;
                free_idx_next = IW'(i);
            end
        end
    end

    always_ff @(posedge aclk) begin
        hit_reg <= hit_next;
        free_ok_reg <= free_next;
        hit_idx_reg <= hit_idx_next;
        free_idx_reg <= free_idx_next;
        if (cmd.capture) begin
            item_reg <= s_item;
        end
    end

    assign wr_idx = hit_reg ? hit_idx_reg : free_idx_reg;
    assign wr_ports = {item_reg.priv_udp_port, item_reg.priv_tcp_port};

    assign age = now_reg - rd_seen_reg;
    assign expire = sweep_chk_reg && (age > {16'd0, timeout});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
            now_reg <= '0;
            sweep_cnt_reg <= '0;
            sweep_chk_reg <= 1'b0;
        end else begin
            if (cmd.tick) begin
                now_reg <= now_reg + 32'd1;
            end
            if (cmd.write_reg) begin
                valid_reg[wr_idx] <= 1'b1;
            end
            if (expire) begin
                valid_reg[sweep_idx_reg] <= 1'b0;
            end
            if (cmd.sweep_start) begin
                sweep_cnt_reg <= '0;
                sweep_chk_reg <= 1'b0;
            end else if (cmd.sweep_step) begin
                sweep_chk_reg <= (sweep_cnt_reg < CW'(D));
                if (sweep_cnt_reg < CW'(D)) begin
                    sweep_cnt_reg <= sweep_cnt_reg + CW'(1);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        sweep_idx_reg <= sweep_cnt_reg[IW-1:0];
        if (cmd.write_reg) begin
            id_reg[wr_idx] <= item_reg.node_id;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.write_reg) begin
            pub_tcp_mem[wr_idx] <= item_reg.priv_tcp_port;
            priv_ip_mem[wr_idx] <= item_reg.priv_ip;
            priv_ports_mem[wr_idx] <= wr_ports;
        end
        if (cmd.read_entry) begin
            rd_pub_tcp_reg <= pub_tcp_mem[hit_idx_reg];
            rd_priv_ip_reg <= priv_ip_mem[hit_idx_reg];
            rd_priv_ports_reg <= priv_ports_mem[hit_idx_reg];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.write_reg || cmd.write_ka) begin
            pub_ip_mem[wr_idx] <= item_reg.src_ip;
            pub_udp_mem[wr_idx] <= item_reg.src_udp_port;
        end
        if (cmd.read_entry) begin
            rd_pub_ip_reg <= pub_ip_mem[hit_idx_reg];
            rd_pub_udp_reg <= pub_udp_mem[hit_idx_reg];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.write_reg || cmd.write_ka) begin
            seen_mem[wr_idx] <= now_reg;
        end
        rd_seen_reg <= seen_mem[sweep_cnt_reg[IW-1:0]];
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_first) begin
            out_reg.dest_ip <= item_reg.src_ip;
            out_reg.dest_udp_port <= item_reg.src_udp_port;
            out_reg.about_id <= item_reg.target_id;
            out_reg.pub_ip <= rd_pub_ip_reg;
            out_reg.pub_udp_port <= rd_pub_udp_reg;
            out_reg.pub_tcp_port <= rd_pub_tcp_reg;
            out_reg.local_ip <= rd_priv_ip_reg;
            out_reg.local_udp_port <= rd_priv_ports_reg[31:16];
            out_reg.local_tcp_port <= rd_priv_ports_reg[15:0];
            out_reg.last <= 1'b0;
        end else if (cmd.load_second) begin
            out_reg.dest_ip <= rd_pub_ip_reg;
            out_reg.dest_udp_port <= rd_pub_udp_reg;
            out_reg.about_id <= item_reg.node_id;
            out_reg.pub_ip <= item_reg.src_ip;
            out_reg.pub_udp_port <= item_reg.src_udp_port;
            out_reg.pub_tcp_port <= item_reg.priv_tcp_port;
            out_reg.local_ip <= item_reg.priv_ip;
            out_reg.local_udp_port <= item_reg.priv_udp_port;
            out_reg.local_tcp_port <= item_reg.priv_tcp_port;
            out_reg.last <= 1'b1;
        end
    end

    assign m_item = out_reg;
    assign st.kind = item_reg.kind;
    assign st.hit = hit_reg;
    assign st.free_ok = free_ok_reg;
    assign st.sweep_done = (sweep_cnt_reg == CW'(D)) && !sweep_chk_reg;

    `PTWA_ASSERT(a_write_has_slot, aclk, aresetn, cmd.write_reg |-> (hit_reg || free_ok_reg), "register write without a slot")
    `PTWA_ASSERT(a_second_is_last, aclk, aresetn, cmd.load_second |=> out_reg.last, "second notify not marked last")
    `PTWA_ASSERT(a_tick_advances, aclk, aresetn, cmd.tick |=> (now_reg == $past(now_reg) + 32'd1), "seconds clock did not advance")
    `PTWA_ASSERT_ALWAYS(a_no_write_in_sweep, aclk, !(expire && (cmd.write_reg || cmd.write_ka)), "entry update during sweep")

endmodule

// ===== src/peer_table_with_aging.sv =====
// Top level of the peer table with aging: APB timeout register and the
// controller and datapath. Depends on ptwa_pkg, ptwa_ctrl and ptwa_dp.
//
// The block holds up to ptwa_pkg::TABLE_DEPTH peers keyed by a 64-bit node id
// and handles one item at a time. A tick, register or keepalive item goes through
// capture of the item, the parallel id compare and the update of the entry or the
// seconds clock in turn. A request is captured, compared, has its entry read and
// its first notify loaded before that notify is offered, and the two notifies then
// leave as fast as m_ready takes them. A sweep walks the seen-time memory through
// its single read port, one entry per cycle. The timeout register sits at byte address 0.
module peer_table_with_aging (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  ptwa_pkg::in_item_t               s_item,
    output logic                             m_valid,
    input  logic                             m_ready,
    output ptwa_pkg::out_item_t              m_item,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [ptwa_pkg::PADDR_W-1:0]     paddr,
    input  logic [31:0]                      pwdata,
    output logic [31:0]                      prdata,
    output logic                             pready
);

    ptwa_pkg::cmd_t    cmd;
    ptwa_pkg::status_t st;
    logic [15:0]       timeout_reg;

    assign pready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            timeout_reg <= ptwa_pkg::TIMEOUT_RESET;
        end else if (psel && penable && pwrite && (paddr[2] == ptwa_pkg::REG_TIMEOUT)) begin
            timeout_reg <= pwdata[15:0];
        end
    end

    assign prdata = (paddr[2] == ptwa_pkg::REG_TIMEOUT) ? {16'd0, timeout_reg} : 32'd0;

    ptwa_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .st      (st),
        .cmd     (cmd)
    );

    ptwa_dp u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (cmd),
        .st      (st),
        .s_item  (s_item),
        .timeout (timeout_reg),
        .m_item  (m_item)
    );

endmodule

// ===== tb/sv/tb_peer_table_with_aging.sv =====
// Self-checking testbench for peer_table_with_aging: directed and random items
// checked against a behavioral peer table with aging kept inside the bench.
// Depends on ptwa_pkg and the peer_table_with_aging RTL only.
`timescale 1ns / 1ps

module tb_peer_table_with_aging;

    localparam logic [2:0] KIND_SPARE_LO = 3'd5;
    localparam logic [2:0] KIND_SPARE_HI = 3'd7;
    localparam int POOL_SIZE = 48;
    localparam int SETTLE_CYCLES = ptwa_pkg::TABLE_DEPTH + 16;
    localparam int IDLE_LIMIT = 4000;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    ptwa_pkg::in_item_t s_item = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    ptwa_pkg::out_item_t m_item;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [ptwa_pkg::PADDR_W-1:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;

    // Bench copy of the peer table.
    logic        peer_valid [ptwa_pkg::TABLE_DEPTH];
    logic [63:0] peer_id [ptwa_pkg::TABLE_DEPTH];
    logic [31:0] peer_pub_ip [ptwa_pkg::TABLE_DEPTH];
    logic [15:0] peer_pub_udp [ptwa_pkg::TABLE_DEPTH];
    logic [15:0] peer_pub_tcp [ptwa_pkg::TABLE_DEPTH];
    logic [31:0] peer_priv_ip [ptwa_pkg::TABLE_DEPTH];
    logic [15:0] peer_priv_udp [ptwa_pkg::TABLE_DEPTH];
    logic [15:0] peer_priv_tcp [ptwa_pkg::TABLE_DEPTH];
    logic [31:0] peer_seen [ptwa_pkg::TABLE_DEPTH];
    logic [31:0] clock_seconds = '0;
    logic [15:0] idle_timeout = ptwa_pkg::TIMEOUT_RESET;

    ptwa_pkg::out_item_t pending_notifies[$];
    logic [63:0] id_pool [POOL_SIZE];
    int errors = 0;
    int items_sent = 0;
    int notifies_seen = 0;
    int hold_request = 0;
    int idle_cycles = 0;

    peer_table_with_aging dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_item(s_item),
        .m_valid(m_valid), .m_ready(m_ready), .m_item(m_item),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    function automatic int lookup_peer(logic [63:0] id);
        for (int i = 0; i < ptwa_pkg::TABLE_DEPTH; i++)
            if (peer_valid[i] && peer_id[i] == id) return i;
        return -1;
    endfunction

    function automatic void predict_notifies(ptwa_pkg::in_item_t it);
        int slot;
        ptwa_pkg::out_item_t n;
        case (it.kind)
            ptwa_pkg::KIND_TICK: clock_seconds = clock_seconds + 32'd1;
            ptwa_pkg::KIND_SWEEP: begin
                for (int i = 0; i < ptwa_pkg::TABLE_DEPTH; i++)
                    if (peer_valid[i] && (clock_seconds - peer_seen[i]) > {16'd0, idle_timeout})
                        peer_valid[i] = 1'b0;
            end
            ptwa_pkg::KIND_REGISTER: begin
                slot = lookup_peer(it.node_id);
                if (slot < 0)
                    for (int i = ptwa_pkg::TABLE_DEPTH - 1; i >= 0; i--)
                        if (!peer_valid[i]) slot = i;
                if (slot >= 0) begin
                    peer_valid[slot] = 1'b1;
                    peer_id[slot] = it.node_id;
                    peer_pub_ip[slot] = it.src_ip;
                    peer_pub_udp[slot] = it.src_udp_port;
                    peer_pub_tcp[slot] = it.priv_tcp_port;
                    peer_priv_ip[slot] = it.priv_ip;
                    peer_priv_udp[slot] = it.priv_udp_port;
                    peer_priv_tcp[slot] = it.priv_tcp_port;
                    peer_seen[slot] = clock_seconds;
                end
            end
            ptwa_pkg::KIND_KEEPALIVE: begin
                slot = lookup_peer(it.node_id);
                if (slot >= 0) begin
                    peer_seen[slot] = clock_seconds;
                    peer_pub_ip[slot] = it.src_ip;
                    peer_pub_udp[slot] = it.src_udp_port;
                end
            end
            ptwa_pkg::KIND_REQUEST: begin
                slot = lookup_peer(it.target_id);
                if (slot >= 0) begin
                    n.dest_ip = it.src_ip;
                    n.dest_udp_port = it.src_udp_port;
                    n.about_id = peer_id[slot];
                    n.pub_ip = peer_pub_ip[slot];
                    n.pub_udp_port = peer_pub_udp[slot];
                    n.pub_tcp_port = peer_pub_tcp[slot];
                    n.local_ip = peer_priv_ip[slot];
                    n.local_udp_port = peer_priv_udp[slot];
                    n.local_tcp_port = peer_priv_tcp[slot];
                    n.last = 1'b0;
                    pending_notifies.push_back(n);
                    n.dest_ip = peer_pub_ip[slot];
                    n.dest_udp_port = peer_pub_udp[slot];
                    n.about_id = it.node_id;
                    n.pub_ip = it.src_ip;
                    n.pub_udp_port = it.src_udp_port;
                    n.pub_tcp_port = it.priv_tcp_port;
                    n.local_ip = it.priv_ip;
                    n.local_udp_port = it.priv_udp_port;
                    n.local_tcp_port = it.priv_tcp_port;
                    n.last = 1'b1;
                    pending_notifies.push_back(n);
                end
            end
            default: ;
        endcase
    endfunction

    function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
        if (want !== got) begin
            errors++;
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
        end
    endfunction

    always @(posedge aclk) begin
        ptwa_pkg::out_item_t want;
        if (aresetn && m_valid && m_ready) begin
            notifies_seen++;
            if (pending_notifies.size() == 0) begin
                errors++;
                $display("%0t: unexpected notify, expected none, actual %h", $time, m_item);
            end else begin
                want = pending_notifies.pop_front();
                check_field("dest_ip", 64'(want.dest_ip), 64'(m_item.dest_ip));
                check_field("dest_udp_port", 64'(want.dest_udp_port),
                            64'(m_item.dest_udp_port));
                check_field("about_id", want.about_id, m_item.about_id);
                check_field("pub_ip", 64'(want.pub_ip), 64'(m_item.pub_ip));
                check_field("pub_udp_port", 64'(want.pub_udp_port), 64'(m_item.pub_udp_port));
                check_field("pub_tcp_port", 64'(want.pub_tcp_port), 64'(m_item.pub_tcp_port));
                check_field("local_ip", 64'(want.local_ip), 64'(m_item.local_ip));
                check_field("local_udp_port", 64'(want.local_udp_port),
                            64'(m_item.local_udp_port));
                check_field("local_tcp_port", 64'(want.local_tcp_port),
                            64'(m_item.local_tcp_port));
                check_field("last", 64'(want.last), 64'(m_item.last));
            end
        end
    end

    // Receiver: mostly short random stalls, a few long ones, and a forced hold-off on request.
    always @(negedge aclk) begin
        int stall_left;
        if (hold_request > 0) begin
            stall_left = hold_request;
            hold_request = 0;
        end
        if (stall_left > 0) begin
            stall_left--;
            m_ready <= 1'b0;
        end else if ($urandom_range(0, 149) == 0) begin
            stall_left = $urandom_range(10, 60);
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(0, 99) < 70);
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || psel) idle_cycles = 0;
        else idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("timeout after %0d cycles without progress", IDLE_LIMIT);
            $display("peer_table_with_aging test failed");
            $finish;
        end
    end

    // Called just after a falling edge; returns just after a falling edge.
    task automatic send_item(ptwa_pkg::in_item_t it);
        int gap;
        s_valid <= 1'b1;
        s_item <= it;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        predict_notifies(it);
        items_sent++;
        @(negedge aclk);
        gap = $urandom_range(0, 99);
        gap = (gap < 55) ? 0 : (gap < 92) ? $urandom_range(1, 3) : $urandom_range(5, 30);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
    endtask

    task automatic drain_notifies();
        s_valid <= 1'b0;
        while (pending_notifies.size() != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic write_timeout(logic [15:0] value);
        drain_notifies();
        psel <= 1'b1;
        pwrite <= 1'b1;
        paddr <= ptwa_pkg::PADDR_W'(4 * ptwa_pkg::REG_TIMEOUT);
        pwdata <= {16'd0, value};
        @(negedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        idle_timeout = value;
        @(negedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    function automatic ptwa_pkg::in_item_t make_item(logic [2:0] kind, logic [63:0] node,
                                                     logic [63:0] target);
        ptwa_pkg::in_item_t it;
        it.kind = kind;
        it.node_id = node;
        it.target_id = target;
        it.src_ip = $urandom;
        it.src_udp_port = 16'($urandom);
        it.priv_ip = $urandom;
        it.priv_udp_port = 16'($urandom);
        it.priv_tcp_port = 16'($urandom);
        return it;
    endfunction

    function automatic logic [63:0] pick_id();
        if ($urandom_range(0, 99) < 85) return id_pool[$urandom_range(0, POOL_SIZE - 1)];
        return {$urandom, $urandom};
    endfunction

    task automatic test_directed();
        ptwa_pkg::in_item_t it;
        it = '0;
        it.kind = ptwa_pkg::KIND_REGISTER;
        send_item(it);
        it = '1;
        it.kind = ptwa_pkg::KIND_REGISTER;
        send_item(it);
        it = '0;
        it.kind = ptwa_pkg::KIND_REQUEST;
        it.target_id = '1;
        send_item(it);
        it = '1;
        it.kind = ptwa_pkg::KIND_REQUEST;
        it.target_id = '0;
        send_item(it);
        send_item(make_item(ptwa_pkg::KIND_KEEPALIVE, 64'h1234_5678_9abc_def0, '0));
        send_item(make_item(ptwa_pkg::KIND_REQUEST, '0, 64'h1234_5678_9abc_def0));
        send_item(make_item(ptwa_pkg::KIND_TICK, '0, '0));
        send_item(make_item(ptwa_pkg::KIND_KEEPALIVE, '1, '0));
        send_item(make_item(ptwa_pkg::KIND_REGISTER, '0, '0));
        send_item(make_item(ptwa_pkg::KIND_REQUEST, '1, '0));
        for (int k = KIND_SPARE_LO; k <= KIND_SPARE_HI; k++)
            send_item(make_item(3'(k), id_pool[0], '1));
        send_item(make_item(ptwa_pkg::KIND_SWEEP, '0, '0));
        send_item(make_item(ptwa_pkg::KIND_REQUEST, id_pool[1], '0));
        // Zero timeout: one second of age is enough for removal of the idle entry.
        write_timeout(16'd0);
        send_item(make_item(ptwa_pkg::KIND_KEEPALIVE, '1, '0));
        send_item(make_item(ptwa_pkg::KIND_TICK, '0, '0));
        send_item(make_item(ptwa_pkg::KIND_KEEPALIVE, '0, '0));
        send_item(make_item(ptwa_pkg::KIND_SWEEP, '0, '0));
        send_item(make_item(ptwa_pkg::KIND_REQUEST, id_pool[2], '1));
        send_item(make_item(ptwa_pkg::KIND_REQUEST, id_pool[3], '0));
        drain_notifies();
    endtask

    task automatic test_table_full();
        write_timeout(16'hffff);
        for (int i = 0; i < ptwa_pkg::TABLE_DEPTH; i++)
            send_item(make_item(ptwa_pkg::KIND_REGISTER, {32'hfeed_0000, 32'(i)}, '0));
        send_item(make_item(ptwa_pkg::KIND_REGISTER, 64'hdead_beef_0000_0001, '0));
        send_item(make_item(ptwa_pkg::KIND_REQUEST, id_pool[4], 64'hdead_beef_0000_0001));
        send_item(make_item(ptwa_pkg::KIND_REGISTER, {32'hfeed_0000, 32'd5}, '0));
        send_item(make_item(ptwa_pkg::KIND_REQUEST, id_pool[4], {32'hfeed_0000, 32'd5}));
        // Clear the table again so the tests that follow start with free entries.
        write_timeout(16'd0);
        send_item(make_item(ptwa_pkg::KIND_TICK, '0, '0));
        send_item(make_item(ptwa_pkg::KIND_SWEEP, '0, '0));
        drain_notifies();
    endtask

    task automatic test_output_backpressure();
        write_timeout(ptwa_pkg::TIMEOUT_RESET);
        for (int i = 0; i < 4; i++)
            send_item(make_item(ptwa_pkg::KIND_REGISTER, id_pool[i], '0));
        hold_request = 300;
        for (int i = 0; i < 24; i++)
            send_item(make_item(ptwa_pkg::KIND_REQUEST, pick_id(), id_pool[i % 4]));
        drain_notifies();
    endtask

    task automatic test_random_traffic(logic [15:0] timeout_value, int count);
        ptwa_pkg::in_item_t it;
        int r;
        write_timeout(timeout_value);
        for (int n = 0; n < count; n++) begin
            r = $urandom_range(0, 99);
            it = make_item(ptwa_pkg::KIND_TICK, pick_id(), pick_id());
            if (r < 18) it.kind = ptwa_pkg::KIND_TICK;
            else if (r < 24) it.kind = ptwa_pkg::KIND_SWEEP;
            else if (r < 48) it.kind = ptwa_pkg::KIND_REGISTER;
            else if (r < 66) it.kind = ptwa_pkg::KIND_KEEPALIVE;
            else if (r < 96) it.kind = ptwa_pkg::KIND_REQUEST;
            else it.kind = 3'($urandom_range(KIND_SPARE_LO, KIND_SPARE_HI));
            send_item(it);
        end
    endtask

    initial begin
        for (int i = 0; i < POOL_SIZE; i++) id_pool[i] = {$urandom, $urandom};
        for (int i = 0; i < ptwa_pkg::TABLE_DEPTH; i++) peer_valid[i] = 1'b0;
        repeat (2) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        test_directed();
        test_table_full();
        test_output_backpressure();
        test_random_traffic(16'd0, 50);
        test_random_traffic(16'd1, 60);
        test_random_traffic(16'd7, 60);
        test_random_traffic(16'hffff, 50);
        test_random_traffic(16'd20, 60);
        test_random_traffic(ptwa_pkg::TIMEOUT_RESET, 60);
        drain_notifies();
        $display("Sent %0d items over six timeout settings; %0d notifies checked.",
                 items_sent, notifies_seen);
        $display("Covered table full, unknown ids, spare kinds, zero timeout and long stalls.");
        if (errors == 0) begin
            $display("peer_table_with_aging test passed");
        end else begin
            $display("peer_table_with_aging test failed");
        end
        $finish;
    end
endmodule
